>>> rtl/sbi_pkg.sv
package sbi_pkg;

  // Opcodes of the bytecode.
  localparam logic [7:0] OPC_PUSH = 8'h01;
  localparam logic [7:0] OPC_ADD  = 8'h02;
  localparam logic [7:0] OPC_SUB  = 8'h03;
  localparam logic [7:0] OPC_MUL  = 8'h04;
  localparam logic [7:0] OPC_XOR  = 8'h05;
  localparam logic [7:0] OPC_RET  = 8'hFF;

  // Number of immediate bytes that follow a push.
  localparam logic [2:0] IMM_BYTES = 3'd4;

  typedef enum logic [1:0] {
    ST_RETURNED = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_RAN_OFF  = 2'd2,
    ST_FAULT    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } code_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    status_t            status;
  } result_item_t;

endpackage

>>> rtl/sbi_ram.sv
module sbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/stack_bytecode_interpreter_unit.sv
// Byte-serial stack machine interpreter. A program arrives one byte per item on the code
// channel, its final byte marked by last_byte; each program starts with an empty stack.
// Opcodes are push (0x01, followed by a four-byte big-endian immediate), add (0x02),
// subtract (0x03), multiply (0x04, low 32 bits of the product), xor (0x05) and return
// (0xFF); all arithmetic wraps. Return delivers the top of the stack with status 0. An
// unknown opcode gives status 1, a program that ends without a result gives status 2, and
// a stack overflow or underflow gives status 3, each with value 0. After a result every
// byte up to and including the marked last byte is skipped. The block takes one byte per
// clock cycle while code_ready is high, with no bubbles: the top of the stack lives in a
// register and the entry beneath it is kept prefetched from a single-port-read stack RAM, so
// every operation finishes within the cycle of its byte. Results leave through a two-stage
// output buffer; code_ready falls only when both stages hold results that the consumer has
// not taken. There is no clearing pass after reset, and the first item can be taken at once.
module stack_bytecode_interpreter_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 code_valid,
  output logic                 code_ready,
  input  sbi_pkg::code_item_t  code,
  output logic                 result_valid,
  input  logic                 result_ready,
  output sbi_pkg::result_item_t result
);

  import sbi_pkg::*;

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // Program state. sp counts the entries on the stack; the entry at sp-1 is also held in
  // tos, and the RAM read port shows the entry at sp-2 whenever the stack holds one.
  logic [SP_W-1:0] sp, sp_next;
  logic [2:0]      imm_left, imm_left_next;
  logic [23:0]     imm_acc, imm_acc_next;
  logic            finished, finished_next;
  logic [31:0]     tos, tos_next;

  // Stack RAM ports.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       nos;
  logic [SP_W-1:0]   rd_ptr;

  // Output buffer: a result register and a skid stage behind it.
  result_item_t out_reg, skid_reg;
  logic         out_valid, skid_valid;

  logic         accept;
  logic         have;
  result_item_t new_result;
  logic [31:0]  imm_word;
  logic [31:0]  alu_result;

  assign code_ready   = !skid_valid;
  assign accept       = code_valid && code_ready;
  assign result_valid = out_valid;
  assign result       = out_reg;

  assign imm_word = {imm_acc, code.code_byte};

  // Binary operations take a from the entry beneath the top and b from the top.
  always_comb begin
    case (code.code_byte)
      OPC_ADD: alu_result = nos + tos;
      OPC_SUB: alu_result = nos - tos;
      OPC_MUL: alu_result = nos * tos;
      default: alu_result = nos ^ tos;
    endcase
  end

  always_comb begin
    sp_next       = sp;
    imm_left_next = imm_left;
    imm_acc_next  = imm_acc;
    finished_next = finished;
    tos_next      = tos;
    wr_en         = 1'b0;
    wr_addr       = sp[ADDR_W-1:0];
    wr_data       = imm_word;
    have          = 1'b0;
    new_result.result_value = '0;
    new_result.status       = ST_RETURNED;

    if (accept) begin
      if (finished) begin
        if (code.last_byte) begin
          finished_next = 1'b0;
          sp_next       = '0;
          imm_left_next = '0;
          imm_acc_next  = '0;
        end
      end else begin
        if (imm_left != 3'd0) begin
          imm_left_next = imm_left - 3'd1;
          if (imm_left == 3'd1) begin
            imm_acc_next = '0;
            if (sp == SP_W'(STACK_DEPTH)) begin
              have              = 1'b1;
              new_result.status = ST_FAULT;
            end else begin
              wr_en    = 1'b1;
              wr_addr  = sp[ADDR_W-1:0];
              wr_data  = imm_word;
              tos_next = imm_word;
              sp_next  = sp + SP_W'(1);
            end
          end else begin
            imm_acc_next = {imm_acc[15:0], code.code_byte};
          end
        end else begin
          case (code.code_byte)
            OPC_PUSH: begin
              imm_left_next = IMM_BYTES;
              imm_acc_next  = '0;
            end
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_XOR: begin
              if (sp < SP_W'(2)) begin
                have              = 1'b1;
                new_result.status = ST_FAULT;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = ADDR_W'(sp - SP_W'(2));
                wr_data  = alu_result;
                tos_next = alu_result;
                sp_next  = sp - SP_W'(1);
              end
            end
            OPC_RET: begin
              have = 1'b1;
              if (sp == '0) begin
                new_result.status = ST_FAULT;
              end else begin
                new_result.result_value = tos;
              end
            end
            default: begin
              have              = 1'b1;
              new_result.status = ST_UNKNOWN;
            end
          endcase
        end

        if (!have && code.last_byte) begin
          have              = 1'b1;
          new_result.status = ST_RAN_OFF;
        end

        if (code.last_byte) begin
          sp_next       = '0;
          imm_left_next = '0;
          imm_acc_next  = '0;
          finished_next = 1'b0;
        end else if (have) begin
          finished_next = 1'b1;
        end
      end
    end
  end

  // The read address follows the next stack pointer, so the entry beneath the new top is
  // ready in the next cycle. Except as a program ends, it differs from the write address.
  assign rd_ptr  = sp_next - SP_W'(2);
  assign rd_addr = rd_ptr[ADDR_W-1:0];

  sbi_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(nos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp       <= '0;
      imm_left <= '0;
      imm_acc  <= '0;
      finished <= 1'b0;
    end else begin
      sp       <= sp_next;
      imm_left <= imm_left_next;
      imm_acc  <= imm_acc_next;
      finished <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
  end

  // Output buffer. A new result only arrives while the skid stage is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid) begin
        out_valid <= have;
      end else if (result_ready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= have;
        end
      end else if (have) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result_ready) begin
      out_reg <= skid_valid ? skid_reg : new_result;
    end
    if (out_valid && !result_ready && have) begin
      skid_reg <= new_result;
    end
  end

endmodule

>>> rtl/sbi_checker.sv
module sbi_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  code_valid,
  input logic                  code_ready,
  input sbi_pkg::code_item_t   code,
  input logic                  result_valid,
  input logic                  result_ready,
  input sbi_pkg::result_item_t result
);

  import sbi_pkg::*;

  // A result that waits keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // Back-pressure on code only ever comes from results that are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !code_ready |-> result_valid)
    else $error("code stalled with no result pending");

  // Every status except a return carries value zero.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_RETURNED |-> result.result_value == 32'sd0)
    else $error("non-return result with non-zero value");

  // Nothing is delivered straight out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind stack_bytecode_interpreter_unit sbi_checker u_sbi_checker (.*);

>>> tb/sv/sbi_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the interpreter, runs its own copy of the stack
// machine on every accepted code item and compares each accepted result with
// the oldest outcome still awaited.
module sbi_result_checker #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  code_valid,
  input  logic                  code_ready,
  input  sbi_pkg::code_item_t   code,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  sbi_pkg::result_item_t result,
  output int                    mismatch_count = 0,
  output int                    results_pending = 0
);
  import sbi_pkg::*;

  logic [31:0]  operand_stack [STACK_DEPTH];
  int           stack_height;
  int           imm_bytes_due;
  logic [23:0]  imm_partial;
  bit           skipping;
  result_item_t awaited_results [$];
  int           error_total = 0;

  function automatic void restart_program();
    stack_height  = 0;
    imm_bytes_due = 0;
    imm_partial   = '0;
    skipping      = 1'b0;
  endfunction

  // Advances the machine by one byte; returns 1 when the byte yields a result.
  function automatic bit interpret_byte(input code_item_t item, output result_item_t outcome);
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] folded;
    bit          produced;
    produced             = 1'b0;
    outcome.result_value = '0;
    outcome.status       = ST_RETURNED;
    if (skipping) begin
      if (item.last_byte) restart_program();
      return 1'b0;
    end
    if (imm_bytes_due != 0) begin
      imm_bytes_due--;
      if (imm_bytes_due == 0) begin
        if (stack_height >= STACK_DEPTH) begin
          produced       = 1'b1;
          outcome.status = ST_FAULT;
        end else begin
          operand_stack[stack_height] = {imm_partial, item.code_byte};
          stack_height++;
        end
        imm_partial = '0;
      end else begin
        imm_partial = {imm_partial[15:0], item.code_byte};
      end
    end else begin
      case (item.code_byte)
        OPC_PUSH: begin
          imm_bytes_due = int'(IMM_BYTES);
          imm_partial   = '0;
        end
        OPC_ADD, OPC_SUB, OPC_MUL, OPC_XOR: begin
          if (stack_height < 2) begin
            produced       = 1'b1;
            outcome.status = ST_FAULT;
          end else begin
            upper = operand_stack[stack_height - 1];
            lower = operand_stack[stack_height - 2];
            case (item.code_byte)
              OPC_ADD: folded = lower + upper;
              OPC_SUB: folded = lower - upper;
              OPC_MUL: folded = lower * upper;
              default: folded = lower ^ upper;
            endcase
            operand_stack[stack_height - 2] = folded;
            stack_height--;
          end
        end
        OPC_RET: begin
          produced = 1'b1;
          if (stack_height < 1) begin
            outcome.status = ST_FAULT;
          end else begin
            outcome.result_value = operand_stack[stack_height - 1];
          end
        end
        default: begin
          produced       = 1'b1;
          outcome.status = ST_UNKNOWN;
        end
      endcase
    end
    if (!produced && item.last_byte) begin
      produced       = 1'b1;
      outcome.status = ST_RAN_OFF;
    end
    if (item.last_byte) begin
      restart_program();
    end else if (produced) begin
      skipping = 1'b1;
    end
    return produced;
  endfunction

  always @(posedge clk) begin
    result_item_t predicted;
    result_item_t oldest;
    if (rst) begin
      restart_program();
      awaited_results.delete();
    end else begin
      if (code_valid && code_ready) begin
        if (interpret_byte(code, predicted)) awaited_results.push_back(predicted);
      end
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          $error("Unexpected result: value %0d, status %0d", result.result_value, result.status);
          error_total++;
        end else begin
          oldest = awaited_results.pop_front();
          if (result.result_value !== oldest.result_value) begin
            $error("result_value mismatch: expected %0d, actual %0d",
                   oldest.result_value, result.result_value);
            error_total++;
          end
          if (result.status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, result.status);
            error_total++;
          end
        end
      end
    end
    mismatch_count  <= error_total;
    results_pending <= awaited_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the stack bytecode interpreter. Programs are fed
// one byte per item; the checker beside the block predicts and compares, so
// this module only decides what goes in, when the consumer takes results and
// whether the run passed.
module tb_top;
  import sbi_pkg::*;

  localparam int DEPTH          = 16;
  localparam int QUIET_LIMIT    = 2000;
  localparam int ITEM_TARGET    = 650;
  localparam int PROGRAM_TARGET = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;

  // Kinds of program that the random part draws from.
  typedef enum int {
    SHAPE_WELL,
    SHAPE_RAN_OFF,
    SHAPE_UNDERFLOW,
    SHAPE_UNKNOWN,
    SHAPE_DEEP,
    SHAPE_OVERFLOW,
    SHAPE_NOISE
  } shape_t;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         code_valid   = 1'b0;
  logic         code_ready;
  code_item_t   code         = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_item_t result;

  int mismatch_count;
  int results_pending;

  // The first two are shared by sender and receiver; all change at clock edges.
  logic idle_on      = 1'b1;
  logic hold_request = 1'b0;
  bit   hold_served  = 1'b0;
  int   hold_left    = 0;

  int bytes_sent      = 0;
  int programs_played = 0;
  int quiet_cycles    = 0;

  always #5 clk = ~clk;

  stack_bytecode_interpreter_unit #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_ready  (code_ready),
    .code        (code),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  sbi_result_checker #(
    .STACK_DEPTH(DEPTH)
  ) prediction_check (
    .clk            (clk),
    .rst            (rst),
    .code_valid     (code_valid),
    .code_ready     (code_ready),
    .code           (code),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // The consumer. Normally it takes results at random, or on every cycle
  // when idling is switched off. Once asked, it refuses results for a long
  // stretch so that the two-deep output buffer fills and the block has to
  // push back on the code channel.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      result_ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_served  <= 1'b1;
    end else if (idle_on) begin
      result_ready <= ($urandom_range(99) >= 37);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog: a run in which no item moves on either channel for too long
  // has hung, whatever the cause.
  always @(posedge clk) begin
    if (rst || (code_valid && code_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offers one code item and returns once it has been accepted. Valid is
  // left high so that a following item can go out on the very next cycle;
  // whoever lets time pass without sending must lower it first. Bytes that
  // the block is known to skip are not counted as interpreted items.
  task automatic send_byte(input logic [7:0] value, input logic last, input bit counted = 1'b1);
    while (idle_on && $urandom_range(99) < 37) begin
      code_valid <= 1'b0;
      @(posedge clk);
    end
    code_valid <= 1'b1;
    code       <= '{code_byte: value, last_byte: last};
    do @(posedge clk); while (!code_ready);
    if (counted) bytes_sent++;
    if (last) programs_played++;
  endtask

  // Sends a push with its big-endian immediate. The byte at index stop_at
  // (0 is the opcode) carries the last mark and ends the program there; an
  // index of 5 sends the whole push unmarked.
  task automatic send_push(input logic [31:0] value, input int stop_at);
    logic [7:0] seq [5];
    seq = '{OPC_PUSH, value[31:24], value[23:16], value[15:8], value[7:0]};
    for (int i = 0; i < 5; i++) begin
      send_byte(seq[i], i == stop_at);
      if (i == stop_at) break;
    end
  endtask

  // After a result the block ignores the rest of the program, so the tail
  // may hold anything at all.
  task automatic skip_tail();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1, 1'b0);
  endtask

  // Operands lean towards the values where wrapping arithmetic goes wrong.
  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] binary_op();
    case ($urandom_range(3))
      0:       return OPC_ADD;
      1:       return OPC_SUB;
      2:       return OPC_MUL;
      default: return OPC_XOR;
    endcase
  endfunction

  function automatic logic [7:0] stray_opcode();
    logic [7:0] b;
    do b = 8'($urandom); while (b inside {OPC_PUSH, OPC_ADD, OPC_SUB, OPC_MUL, OPC_XOR, OPC_RET});
    return b;
  endfunction

  // Well-formed programs dominate; the rest are broken in the ways that the
  // block has to report.
  function automatic shape_t pick_shape();
    int r;
    r = $urandom_range(99);
    if (r < 50) return SHAPE_WELL;
    if (r < 62) return SHAPE_RAN_OFF;
    if (r < 72) return SHAPE_UNDERFLOW;
    if (r < 82) return SHAPE_UNKNOWN;
    if (r < 85) return SHAPE_DEEP;
    if (r < 88) return SHAPE_OVERFLOW;
    return SHAPE_NOISE;
  endfunction

  task automatic play_program(input shape_t shape);
    int         height;
    int         steps;
    int         stop_at;
    logic [7:0] op;
    height = 0;
    case (shape)
      SHAPE_DEEP: begin
        // Fill the stack completely, fold it back down and return.
        repeat (DEPTH) send_push(random_word(), 5);
        repeat (DEPTH - 1) send_byte(binary_op(), 1'b0);
        send_byte(OPC_RET, 1'b1);
      end
      SHAPE_OVERFLOW: begin
        // One push too many; sometimes it completes on the final byte,
        // where the fault must win over the missing return.
        repeat (DEPTH) send_push(random_word(), 5);
        stop_at = $urandom_range(4, 5);
        send_push(random_word(), stop_at);
        if (stop_at == 5) skip_tail();
      end
      SHAPE_NOISE: begin
        steps = $urandom_range(1, 6);
        for (int i = 0; i < steps; i++) send_byte(8'($urandom), i == steps - 1);
      end
      SHAPE_UNDERFLOW: begin
        height = $urandom_range(1);
        repeat (height) send_push(random_word(), 5);
        op = (height == 0 && $urandom_range(1)) ? OPC_RET : binary_op();
        if ($urandom_range(1)) begin
          send_byte(op, 1'b1);
        end else begin
          send_byte(op, 1'b0);
          skip_tail();
        end
      end
      default: begin
        // A random body of pushes and operations that never underflows.
        steps = $urandom_range(1, 7);
        for (int s = 0; s < steps; s++) begin
          if (height >= 2 && (height == DEPTH || $urandom_range(1))) begin
            send_byte(binary_op(), 1'b0);
            height--;
          end else begin
            send_push(random_word(), 5);
            height++;
          end
        end
        case (shape)
          SHAPE_WELL: begin
            if ($urandom_range(3) == 0) begin
              send_byte(OPC_RET, 1'b0);
              skip_tail();
            end else begin
              send_byte(OPC_RET, 1'b1);
            end
          end
          SHAPE_RAN_OFF: begin
            if (height >= 2 && $urandom_range(1)) send_byte(binary_op(), 1'b1);
            else send_push(random_word(), $urandom_range(0, 4));
          end
          default: begin
            if ($urandom_range(1)) begin
              send_byte(stray_opcode(), 1'b1);
            end else begin
              send_byte(stray_opcode(), 1'b0);
              skip_tail();
            end
          end
        endcase
      end
    endcase
  endtask

  initial begin
    bit fast_phase_done;
    bit drained;
    fast_phase_done = 1'b0;
    drained         = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed programs. Return, subtract, multiply and xor on an empty stack, an
    // all-zero unknown opcode, wrapping addition of the extreme operands, a
    // push cut short, a push completing on the final byte, and bytes
    // skipped after an early result.
    send_byte(OPC_RET, 1'b1);
    send_byte(8'h00, 1'b1);
    send_push(32'h7FFF_FFFF, 5);
    send_push(32'hFFFF_FFFF, 5);
    send_byte(OPC_ADD, 1'b0);
    send_byte(OPC_RET, 1'b1);
    send_byte(OPC_SUB, 1'b1);
    send_byte(OPC_MUL, 1'b1);
    send_byte(OPC_XOR, 1'b1);
    send_push(32'h1234_5678, 2);
    send_push(32'h8000_0000, 4);
    send_byte(8'hFE, 1'b0);
    send_byte(OPC_RET, 1'b0, 1'b0);
    send_byte(OPC_PUSH, 1'b1, 1'b0);

    // The deep programs are long, so each is made sure of once up front.
    play_program(SHAPE_OVERFLOW);
    play_program(SHAPE_DEEP);

    while (bytes_sent < ITEM_TARGET || programs_played < PROGRAM_TARGET) begin
      // Ask the consumer for its long hold-off while programs keep coming.
      if (bytes_sent >= 200 && !hold_request) hold_request <= 1'b1;
      // A stretch with no idling on either side.
      if (bytes_sent >= 280 && !fast_phase_done && idle_on) idle_on <= 1'b0;
      if (bytes_sent >= 420 && !idle_on) begin
        idle_on         <= 1'b1;
        fast_phase_done = 1'b1;
      end
      // Once, the producer stops until every result has been delivered.
      if (bytes_sent >= 450 && !drained) begin
        code_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        drained = 1'b1;
      end
      play_program(pick_shape());
    end

    code_valid <= 1'b0;
    idle_on    <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    // Give a stray extra result the chance to show itself.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d bytecode programs over %0d interpreted bytes, with random gaps on",
             programs_played, bytes_sent);
    $display("both channels, a long output stall, a full drain and every kind of fault.");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
